FILE: rtl/b62_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package b62_pkg;
    localparam int unsigned RADIX = 62;
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned HALF_W = 64;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0] t_char;

    function automatic t_char digit_to_char(input t_digit d);
        t_char c;
        c = t_char'(7'd48);
        case (d) inside
            [6'd0:6'd9]:   c = t_char'(7'd48 + {1'b0, d});
            [6'd10:6'd35]: c = t_char'(7'd97 + {1'b0, d} - 7'd10);
            [6'd36:6'd61]: c = t_char'(7'd65 + {1'b0, d} - 7'd36);
            default:       c = t_char'(7'd48);
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/b62_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface b62_id_if;
    logic        valid;
    logic        ready;
    logic [63:0] id_high;
    logic [63:0] id_low;
    modport source (output valid, output id_high, output id_low, input ready);
    modport sink (input valid, input id_high, input id_low, output ready);
endinterface

interface b62_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/id128_to_base62_text.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                 handshake
// s_id      in   id_high[64] id_low[64]  valid/ready
// m_char    out  char_code[7] last_char  valid/ready
// a row of DIGIT_COUNT digit cells converts by doubling: the id enters cell 0
// msb first and carries move up one cell per cycle; the conversion is followed by
// DIGIT_COUNT character transactions, one per cycle when m_char is ready.
// synchronous active-low reset returns to idle; input is taken only when idle.
module id128_to_base62_text #(
    parameter int unsigned DIGIT_COUNT = 22
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b62_id_if.sink     s_id,
    b62_char_if.source m_char
);
    import b62_pkg::*;
    localparam int unsigned CW = $clog2(DIGIT_COUNT);
    localparam int unsigned BITS = 2 * HALF_W;
    localparam int unsigned BW = $clog2(BITS + DIGIT_COUNT);
    localparam int unsigned DIV_LAST = BITS + DIGIT_COUNT - 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state              r_state;
    logic [BITS-1:0]     r_shift;
    logic [BW-1:0]       r_bitcnt;
    logic [CW-1:0]       r_charcnt;
    logic [DIGIT_COUNT:0] w_carry;
    logic [DIGIT_COUNT:0] w_ena;
    t_digit              w_digit [DIGIT_COUNT];
    logic                w_clear;
    logic                w_en;
    logic                w_feed;
    logic                w_done;

    assign w_clear = (r_state == S_IDLE);
    assign w_en    = (r_state == S_DIV);
    assign w_feed  = w_en && (r_bitcnt < BW'(BITS));
    assign w_done  = w_en && (r_bitcnt == BW'(DIV_LAST));
    assign w_carry[0] = r_shift[BITS-1];
    assign w_ena[0]   = w_feed;

    // cell 0 holds the least significant digit
    genvar g;
    generate
        for (g = 0; g < DIGIT_COUNT; g++) begin : g_cell
            b62_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (w_clear),
                .i_en    (w_ena[g]),
                .i_carry (w_carry[g]),
                .o_en    (w_ena[g+1]),
                .o_carry (w_carry[g+1]),
                .o_digit (w_digit[g])
            );
        end
    endgenerate

    assign s_id.ready       = (r_state == S_IDLE);
    assign m_char.valid     = (r_state == S_OUT);
    assign m_char.char_code = digit_to_char(w_digit[r_charcnt]);
    assign m_char.last_char = (r_charcnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bitcnt  <= '0;
            r_charcnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_id.valid) begin
                        r_state  <= S_DIV;
                        r_bitcnt <= '0;
                    end
                end
                S_DIV: begin
                    r_bitcnt <= r_bitcnt + 1'b1;
                    if (w_done) begin
                        r_state   <= S_OUT;
                        r_charcnt <= CW'(DIGIT_COUNT - 1);
                    end
                end
                S_OUT: begin
                    if (m_char.ready) begin
                        if (r_charcnt == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_charcnt <= r_charcnt - 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_shift <= {s_id.id_high, s_id.id_low};
        end else if (w_en) begin
            r_shift <= {r_shift[BITS-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/b62_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one base-62 digit: doubles itself plus the carry from the cell below
module b62_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_clear,
    input  wire logic                  i_en,
    input  wire logic                  i_carry,
    output logic                       o_en,
    output logic                       o_carry,
    output b62_pkg::t_digit            o_digit
);
    import b62_pkg::*;
    logic [DIGIT_W:0] w_trial;
    logic             w_wrap;
    t_digit           r_digit;
    t_digit           n_digit;
    logic             r_en;
    logic             r_carry;

    assign w_trial = {r_digit, i_carry};
    assign w_wrap  = (w_trial >= (DIGIT_W+1)'(RADIX));

    always_comb begin
        if (w_wrap) begin
            n_digit = t_digit'(w_trial - (DIGIT_W+1)'(RADIX));
        end else begin
            n_digit = t_digit'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
            r_en    <= 1'b0;
            r_carry <= 1'b0;
        end else begin
            r_en    <= i_en;
            r_carry <= i_en && w_wrap;
            if (i_en) begin
                r_digit <= n_digit;
            end
        end
    end
    assign o_en    = r_en;
    assign o_carry = r_carry;
    assign o_digit = r_digit;
endmodule
`default_nettype wire

FILE: rtl/b62_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module b62_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] i_char_code,
    input wire logic       i_last_char
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken during output");
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_char_code >= 7'd48 && i_char_code <= 7'd122))
        else $error("char out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_code))
        else $error("output dropped");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_char |=> !i_out_valid && i_in_ready)
        else $error("not idle after last");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid && !i_in_ready)
        else $error("not busy after input transaction");
endmodule

bind id128_to_base62_text b62_checker u_b62_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_id.valid),
    .i_in_ready  (s_id.ready),
    .i_out_valid (m_char.valid),
    .i_out_ready (m_char.ready),
    .i_char_code (m_char.char_code),
    .i_last_char (m_char.last_char)
);
`default_nettype wire

FILE: dv/id128_to_base62_text_test.sv
`timescale 1ns / 1ps
`default_nettype none

class b62_text_board;
    logic [6:0] char_q[$];
    logic       last_q[$];
    int         err_count;

    function new();
        err_count = 0;
    endfunction

    // divide the 128-bit id by 62 and queue its 22 characters
    function void note_id(logic [63:0] hi, logic [63:0] lo);
        logic [127:0] quo;
        logic [5:0]   digs[22];
        logic [5:0]   d;
        logic [6:0]   c;
        quo = {hi, lo};
        for (int k = 0; k < 22; k++) begin
            digs[k] = 6'(quo % 128'd62);
            quo = quo / 128'd62;
        end
        for (int k = 0; k < 22; k++) begin
            d = digs[21 - k];
            if (d < 10) begin
                c = 7'd48 + 7'(d);
            end else if (d < 36) begin
                c = 7'd97 + 7'(d) - 7'd10;
            end else begin
                c = 7'd65 + 7'(d) - 7'd36;
            end
            char_q.push_back(c);
            last_q.push_back(k == 21);
        end
    endfunction

    function void check_char(logic [6:0] c, logic l);
        logic [6:0] ec;
        logic       el;
        if (char_q.size() == 0) begin
            $display("%0t: unexpected char expected none actual %h/%b", $time, c, l);
            err_count++;
            return;
        end
        ec = char_q.pop_front();
        el = last_q.pop_front();
        if (ec !== c) begin
            $display("%0t: char_code expected %h actual %h", $time, ec, c);
            err_count++;
        end
        if (el !== l) begin
            $display("%0t: last_char expected %b actual %b", $time, el, l);
            err_count++;
        end
    endfunction
endclass

module id128_to_base62_text_test;
    logic i_clk;
    logic i_rst_n;
    int   send_idle;
    int   recv_idle;
    int   cycle_count = 0;
    b62_text_board board;

    b62_id_if   id_ch();
    b62_char_if char_ch();

    id128_to_base62_text DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_id   (id_ch.sink),
        .m_char (char_ch.source)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        char_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            board.check_char(char_ch.char_code, char_ch.last_char);
        end
        if (cycle_count > 500000) begin
            $display("id128_to_base62_text_test: errors");
            $finish;
        end
    end

    task automatic send_id(logic [63:0] hi, logic [63:0] lo);
        while ($urandom_range(99) < send_idle) begin
            id_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        id_ch.valid <= 1'b1;
        id_ch.id_high <= hi;
        id_ch.id_low <= lo;
        @(posedge i_clk);
        while (!id_ch.ready) @(posedge i_clk);
        board.note_id(hi, lo);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        id_ch.valid = 1'b0;
        id_ch.id_high = '0;
        id_ch.id_low = '0;
        send_idle = 0;
        recv_idle = 0;
        board = new();
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_id('0, '0);
        send_id('1, '1);
        send_id('0, 64'd1);
        send_id('0, 64'd61);
        send_id('0, 64'd62);
        send_id('0, 64'd3843);
        send_id(64'h8000_0000_0000_0000, '0);
        send_id('0, '1);
        send_id('1, '0);
        send_id(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_id(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_id(64'd1, '0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 33 : (ph == 1) ? 56 : 0;
            recv_idle = (ph == 0) ? 56 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < 150; n++) send_id(rand64(), rand64());
        end
        id_ch.valid <= 1'b0;

        while (board.char_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.err_count == 0) begin
            $display("id128_to_base62_text_test: clean");
        end else begin
            $display("id128_to_base62_text_test: errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
